FILE: rtl/core/rcid_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the reference-counted identifier allocator.
package rcid_pkg;

    localparam int ID_W = 8;
    localparam int CNT_W = 16;
    localparam int ACT_W = 3;
    localparam int ST_W = 3;
    localparam int NUM_IDS_DEF = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACQUIRE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET_ALL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SEND_ACQ = 3'd5;

    localparam logic [ST_W-1:0] ST_OK = 3'd0;
    localparam logic [ST_W-1:0] ST_ILLEGAL = 3'd1;
    localparam logic [ST_W-1:0] ST_UNALLOC = 3'd2;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE_FREE = 3'd4;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd5;

    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  id_number;
        logic             keep;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]  id_result;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count_after;
    } t_result;

    typedef struct packed {
        logic   shift;
        logic   write;
        logic   clear;
        t_count wdata;
    } t_ring_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEEK,
        S_SCAN,
        S_APPLY
    } t_state;

endpackage

FILE: rtl/core/rcid_cell.sv
`timescale 1ns / 1ps
// One cell of the count ring: holds a single reference count.
module rcid_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_load,
    input  rcid_pkg::t_count  i_data,
    output rcid_pkg::t_count  o_count
);

    rcid_pkg::t_count r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= i_data;
        end
    end

    assign o_count = r_count;

endmodule

FILE: rtl/core/rcid_ring.sv
`timescale 1ns / 1ps
// Ring of count cells that rotates toward the head cell and is updated there.
module rcid_ring #(
    parameter int NUM_IDS = rcid_pkg::NUM_IDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcid_pkg::t_ring_ctl i_ctl,
    output rcid_pkg::t_count    o_head
);

    rcid_pkg::t_count w_count [NUM_IDS];
    rcid_pkg::t_count w_in    [NUM_IDS];
    logic             w_load  [NUM_IDS];

    for (genvar g = 0; g < NUM_IDS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_in[g]   = i_ctl.write ? i_ctl.wdata : w_count[1];
            assign w_load[g] = i_ctl.write || i_ctl.shift;
        end else if (g == NUM_IDS - 1) begin : g_tail
            assign w_in[g]   = w_count[0];
            assign w_load[g] = i_ctl.shift;
        end else begin : g_mid
            assign w_in[g]   = w_count[g+1];
            assign w_load[g] = i_ctl.shift;
        end

        rcid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_ctl.clear),
            .i_load  (w_load[g]),
            .i_data  (w_in[g]),
            .o_count (w_count[g])
        );
    end

    assign o_head = w_count[0];

endmodule

FILE: rtl/core/refcounted_id_allocator.sv
`timescale 1ns / 1ps
// Top level of the reference-counted identifier allocator.
// The counts live in a ring of NUM_IDS cells that, while seeking or scanning, rotates one
// place per cycle toward a single head cell, where each count is read and updated.
// Reset all, unknown actions and illegal numbers answer on the cycle after start. Acquire,
// release, clear and send-acquire with a number rotate the ring to that entry. Allocate, and
// send-acquire with number zero, first rotate to the round-robin pointer and then walk the
// ring for a free entry. The result beat is shown for one cycle with o_valid, busy is low
// from that cycle on, and the receiver cannot stall it.
module refcounted_id_allocator #(
    parameter int NUM_IDS = rcid_pkg::NUM_IDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rcid_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output rcid_pkg::t_result o_result
);

    localparam logic [rcid_pkg::ID_W-1:0] LAST = rcid_pkg::ID_W'(NUM_IDS - 1);
    localparam logic [rcid_pkg::ID_W-1:0] TOP_ID = rcid_pkg::ID_W'(NUM_IDS);

    rcid_pkg::t_state               r_state, n_state;
    logic [rcid_pkg::ACT_W-1:0]     r_act, n_act;
    logic [rcid_pkg::ID_W-1:0]      r_id, n_id;
    logic                           r_keep, n_keep;
    logic [rcid_pkg::ID_W-1:0]      r_head, n_head;
    logic [rcid_pkg::ID_W-1:0]      r_np, n_np;
    logic [rcid_pkg::ID_W-1:0]      r_target, n_target;
    logic [rcid_pkg::ID_W-1:0]      r_scan, n_scan;
    logic                           r_valid, n_valid;
    rcid_pkg::t_result              r_res, n_res;

    rcid_pkg::t_ring_ctl            w_ctl;
    rcid_pkg::t_count               w_head_cnt;
    rcid_pkg::t_count               w_dec;
    logic                           w_legal;
    logic                           w_alloc_mode;
    logic [rcid_pkg::ID_W-1:0]      w_head_inc;

    rcid_ring #(
        .NUM_IDS (NUM_IDS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcid_pkg::S_IDLE;
            r_head  <= '0;
            r_np    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_np    <= n_np;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_id     <= n_id;
        r_keep   <= n_keep;
        r_target <= n_target;
        r_scan   <= n_scan;
        r_res    <= n_res;
    end

    assign w_legal      = (i_cmd.id_number != '0) && (i_cmd.id_number <= TOP_ID);
    assign w_alloc_mode = (r_act == rcid_pkg::ACT_ALLOC) ||
                          ((r_act == rcid_pkg::ACT_SEND_ACQ) && (r_id == '0));
    assign w_head_inc   = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign w_dec        = w_head_cnt - 1'b1;

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_id     = r_id;
        n_keep   = r_keep;
        n_head   = r_head;
        n_np     = r_np;
        n_target = r_target;
        n_scan   = r_scan;
        n_valid  = 1'b0;
        n_res    = r_res;
        w_ctl    = '0;

        unique case (r_state)
            rcid_pkg::S_IDLE: begin
                if (start) begin
                    n_act  = i_cmd.action;
                    n_id   = i_cmd.id_number;
                    n_keep = i_cmd.keep;
                    n_scan = '0;
                    unique case (i_cmd.action)
                        rcid_pkg::ACT_ALLOC: begin
                            n_target = r_np;
                            n_state  = rcid_pkg::S_SEEK;
                        end
                        rcid_pkg::ACT_ACQUIRE, rcid_pkg::ACT_RELEASE,
                        rcid_pkg::ACT_CLEAR, rcid_pkg::ACT_SEND_ACQ: begin
                            if ((i_cmd.action == rcid_pkg::ACT_SEND_ACQ) &&
                                (i_cmd.id_number == '0)) begin
                                n_target = r_np;
                                n_state  = rcid_pkg::S_SEEK;
                            end else if (!w_legal) begin
                                n_valid = 1'b1;
                                n_res   = '{i_cmd.id_number, rcid_pkg::ST_ILLEGAL, '0};
                            end else begin
                                n_target = i_cmd.id_number - 1'b1;
                                n_state  = rcid_pkg::S_SEEK;
                            end
                        end
                        rcid_pkg::ACT_RESET_ALL: begin
                            // Every entry reads zero afterward, so any head label is consistent.
                            w_ctl.clear = 1'b1;
                            n_head      = '0;
                            n_np        = '0;
                            n_valid     = 1'b1;
                            n_res       = '{'0, rcid_pkg::ST_OK, '0};
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_res   = '{'0, rcid_pkg::ST_ILLEGAL, '0};
                        end
                    endcase
                end
            end
            rcid_pkg::S_SEEK: begin
                if (r_head == r_target) begin
                    n_state = w_alloc_mode ? rcid_pkg::S_SCAN : rcid_pkg::S_APPLY;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_head      = w_head_inc;
                end
            end
            rcid_pkg::S_SCAN: begin
                if (w_head_cnt == '0) begin
                    // Send-acquire allocates and then acquires, so it lands on a count of two.
                    w_ctl.write = 1'b1;
                    w_ctl.wdata = (r_act == rcid_pkg::ACT_ALLOC) ?
                                  rcid_pkg::CNT_W'(1) : rcid_pkg::CNT_W'(2);
                    n_np        = w_head_inc;
                    n_valid     = 1'b1;
                    n_res       = '{r_head + 1'b1, rcid_pkg::ST_OK, w_ctl.wdata};
                    n_state     = rcid_pkg::S_IDLE;
                end else if (r_scan == LAST) begin
                    n_valid = 1'b1;
                    n_res   = '{'0, rcid_pkg::ST_NONE_FREE, '0};
                    n_state = rcid_pkg::S_IDLE;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_head      = w_head_inc;
                    n_scan      = r_scan + 1'b1;
                end
            end
            rcid_pkg::S_APPLY: begin
                n_valid = 1'b1;
                n_state = rcid_pkg::S_IDLE;
                case (r_act)
                    rcid_pkg::ACT_RELEASE: begin
                        if (w_head_cnt == '0) begin
                            n_res = '{r_id, rcid_pkg::ST_UNALLOC, '0};
                        end else if (w_dec == '0) begin
                            w_ctl.write = 1'b1;
                            w_ctl.wdata = '0;
                            n_res       = '{r_id, rcid_pkg::ST_UNDERFLOW, '0};
                        end else begin
                            w_ctl.write = 1'b1;
                            w_ctl.wdata = ((w_dec == rcid_pkg::CNT_W'(1)) && !r_keep) ?
                                          '0 : w_dec;
                            n_res       = '{r_id, rcid_pkg::ST_OK, w_ctl.wdata};
                        end
                    end
                    rcid_pkg::ACT_CLEAR: begin
                        w_ctl.write = 1'b1;
                        w_ctl.wdata = '0;
                        n_res       = '{r_id, rcid_pkg::ST_OK, '0};
                    end
                    default: begin
                        if (w_head_cnt == '0) begin
                            n_res = '{r_id, rcid_pkg::ST_UNALLOC, '0};
                        end else if (w_head_cnt == rcid_pkg::COUNT_MAX) begin
                            n_res = '{r_id, rcid_pkg::ST_OVERFLOW, rcid_pkg::COUNT_MAX};
                        end else begin
                            w_ctl.write = 1'b1;
                            w_ctl.wdata = w_head_cnt + 1'b1;
                            n_res       = '{r_id, rcid_pkg::ST_OK, w_ctl.wdata};
                        end
                    end
                endcase
            end
            default: begin
                n_state = rcid_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != rcid_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

FILE: rtl/core/rcid_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the reference-counted identifier allocator and its bind.
module rcid_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input rcid_pkg::t_cmd    i_cmd,
    input logic              o_valid,
    input rcid_pkg::t_result o_result
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("Accepted beat produced neither busy nor a result.");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result beat shown while still busy.");

    a_reset_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.action == rcid_pkg::ACT_RESET_ALL)) |=>
        (o_valid && (o_result.status == rcid_pkg::ST_OK) &&
         (o_result.id_result == '0) && (o_result.count_after == '0)))
        else $error("Reset all did not answer with a cleared result.");

    a_none_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == rcid_pkg::ST_NONE_FREE)) |->
        ((o_result.id_result == '0) && (o_result.count_after == '0)))
        else $error("None-free result carries a number or a count.");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == rcid_pkg::ST_OVERFLOW)) |->
        (o_result.count_after == rcid_pkg::COUNT_MAX))
        else $error("Overflow result does not show a saturated count.");

endmodule

bind refcounted_id_allocator rcid_checker u_rcid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the reference-counted identifier allocator.
module tb_top;

    localparam int NIDS = rcid_pkg::NUM_IDS_DEF;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 2 * NIDS + 8;
    localparam int CMD_W = $bits(rcid_pkg::t_cmd);
    localparam logic [rcid_pkg::ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [rcid_pkg::ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    rcid_pkg::t_cmd    i_cmd = '0;
    logic              o_valid;
    rcid_pkg::t_result o_result;

    rcid_pkg::t_result pending_results [$];
    rcid_pkg::t_count  id_counts [NIDS] = '{default: '0};
    int unsigned       alloc_ptr = 0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       idle_pct = 0;

    refcounted_id_allocator #(
        .NUM_IDS(NIDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic rcid_pkg::t_result make_result(int unsigned idn,
                                                      logic [rcid_pkg::ST_W-1:0] st,
                                                      rcid_pkg::t_count cnt);
        return '{id_result: idn[rcid_pkg::ID_W-1:0], status: st, count_after: cnt};
    endfunction

    function automatic rcid_pkg::t_cmd make_cmd(logic [rcid_pkg::ACT_W-1:0] act,
                                                int unsigned idn, bit kp);
        return '{action: act, id_number: idn[rcid_pkg::ID_W-1:0], keep: kp};
    endfunction

    function automatic void reset_table();
        foreach (id_counts[k]) id_counts[k] = '0;
        alloc_ptr = 0;
    endfunction

    function automatic int unsigned claim_free_id();
        int unsigned slot;
        for (int unsigned k = 0; k < NIDS; k++) begin
            slot = (alloc_ptr + k) % NIDS;
            if (id_counts[slot] == '0) begin
                id_counts[slot] = rcid_pkg::t_count'(1);
                alloc_ptr = (slot + 1) % NIDS;
                return slot + 1;
            end
        end
        return 0;
    endfunction

    function automatic bit id_legal(int unsigned idn);
        return idn >= 1 && idn <= NIDS;
    endfunction

    function automatic rcid_pkg::t_result adjust_count(int unsigned idn, bit up, bit keep_one);
        rcid_pkg::t_count cnt;
        if (!id_legal(idn)) return make_result(idn, rcid_pkg::ST_ILLEGAL, '0);
        cnt = id_counts[idn-1];
        if (cnt == '0) return make_result(idn, rcid_pkg::ST_UNALLOC, '0);
        if (up) begin
            if (cnt == rcid_pkg::COUNT_MAX) begin
                return make_result(idn, rcid_pkg::ST_OVERFLOW, rcid_pkg::COUNT_MAX);
            end
            cnt++;
        end else begin
            cnt--;
            if (cnt == '0) begin
                id_counts[idn-1] = '0;
                return make_result(idn, rcid_pkg::ST_UNDERFLOW, '0);
            end
        end
        if (cnt == 1 && !keep_one) cnt = '0;
        id_counts[idn-1] = cnt;
        return make_result(idn, rcid_pkg::ST_OK, cnt);
    endfunction

    function automatic rcid_pkg::t_result predict_result(rcid_pkg::t_cmd c);
        int unsigned idn;
        rcid_pkg::t_result r;
        idn = 32'(c.id_number);
        case (c.action)
            rcid_pkg::ACT_ALLOC: begin
                idn = claim_free_id();
                r = (idn == 0) ? make_result(0, rcid_pkg::ST_NONE_FREE, '0) :
                                 make_result(idn, rcid_pkg::ST_OK, rcid_pkg::t_count'(1));
            end
            rcid_pkg::ACT_ACQUIRE: r = adjust_count(idn, 1'b1, 1'b0);
            rcid_pkg::ACT_RELEASE: r = adjust_count(idn, 1'b0, c.keep);
            rcid_pkg::ACT_CLEAR: begin
                if (!id_legal(idn)) begin
                    r = make_result(idn, rcid_pkg::ST_ILLEGAL, '0);
                end else begin
                    id_counts[idn-1] = '0;
                    r = make_result(idn, rcid_pkg::ST_OK, '0);
                end
            end
            rcid_pkg::ACT_RESET_ALL: begin
                reset_table();
                r = make_result(0, rcid_pkg::ST_OK, '0);
            end
            rcid_pkg::ACT_SEND_ACQ: begin
                if (idn == 0) idn = claim_free_id();
                if (idn == 0) r = make_result(0, rcid_pkg::ST_NONE_FREE, '0);
                else r = adjust_count(idn, 1'b1, 1'b0);
            end
            default: r = make_result(0, rcid_pkg::ST_ILLEGAL, '0);
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        rcid_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result beat %p", $time, o_result);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.id_result !== want.id_result) begin
                        error_count++;
                        $display("%0t: id_result expected %0d, got %0d",
                                 $time, want.id_result, o_result.id_result);
                    end
                    if (o_result.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_result.status);
                    end
                    if (o_result.count_after !== want.count_after) begin
                        error_count++;
                        $display("%0t: count_after expected %0d, got %0d",
                                 $time, want.count_after, o_result.count_after);
                    end
                end
            end
            if (start && !busy) pending_results.push_back(predict_result(i_cmd));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_cmd(input rcid_pkg::t_cmd c);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_cmd <= CMD_W'($urandom_range(4095));
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_and_unknown();
        send_cmd(make_cmd(rcid_pkg::ACT_RESET_ALL, 255, 1'b1));
        send_cmd(make_cmd(ACT_UNUSED_6, 255, 1'b1));
        send_cmd(make_cmd(ACT_UNUSED_7, 0, 1'b0));
    endtask

    task automatic test_illegal_numbers();
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, NIDS + 1, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_CLEAR, 255, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_CLEAR, 0, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, 128, 1'b0));
    endtask

    task automatic test_lifecycle();
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 1, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 1, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 1, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 1, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 1, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 1, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 2, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 3, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 3, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 3, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, 4, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, 10, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_CLEAR, 4, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_CLEAR, 5, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, NIDS, 1'b0));
    endtask

    task automatic test_full_table();
        send_cmd(make_cmd(rcid_pkg::ACT_RESET_ALL, 0, 1'b0));
        repeat (NIDS) begin
            send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, $urandom_range(255),
                              1'($urandom_range(1))));
        end
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, 0, 1'b1));
        send_cmd(make_cmd(rcid_pkg::ACT_SEND_ACQ, NIDS, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_CLEAR, 20, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RESET_ALL, 0, 1'b0));
    endtask

    task automatic test_count_climb();
        send_cmd(make_cmd(rcid_pkg::ACT_RESET_ALL, 0, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_ALLOC, 0, 1'b0));
        repeat (24) send_cmd(make_cmd(rcid_pkg::ACT_ACQUIRE, 1, 1'($urandom_range(1))));
        send_cmd(make_cmd(rcid_pkg::ACT_RELEASE, 1, 1'b0));
        send_cmd(make_cmd(rcid_pkg::ACT_RESET_ALL, 0, 1'b0));
    endtask

    function automatic int unsigned pick_id();
        int unsigned r;
        int unsigned base;
        r = $urandom_range(99);
        if (r < 8) return $urandom_range(255);
        if (r < 75) begin
            base = $urandom_range(NIDS - 1);
            for (int unsigned k = 0; k < NIDS; k++)
                if (id_counts[(base + k) % NIDS] != '0) return (base + k) % NIDS + 1;
        end
        return $urandom_range(NIDS, 1);
    endfunction

    task automatic test_random(input int unsigned n);
        int unsigned r;
        rcid_pkg::t_cmd c;
        repeat (n) begin
            r = $urandom_range(99);
            c = make_cmd(rcid_pkg::ACT_ACQUIRE, pick_id(), 1'($urandom_range(1)));
            if (r < 22) c.action = rcid_pkg::ACT_ALLOC;
            else if (r < 44) c.action = rcid_pkg::ACT_ACQUIRE;
            else if (r < 70) c.action = rcid_pkg::ACT_RELEASE;
            else if (r < 76) c.action = rcid_pkg::ACT_CLEAR;
            else if (r < 78) c.action = rcid_pkg::ACT_RESET_ALL;
            else if (r < 96) begin
                c.action = rcid_pkg::ACT_SEND_ACQ;
                if ($urandom_range(1)) c.id_number = '0;
            end else begin
                c.action = rcid_pkg::ACT_W'($urandom_range(7));
            end
            send_cmd(c);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 32;
        test_reset_and_unknown();
        test_illegal_numbers();
        test_lifecycle();
        drain_results();
        test_full_table();
        test_random(280);
        drain_results();

        idle_pct = 61;
        test_random(280);
        drain_results();

        idle_pct = 0;
        test_count_climb();
        test_random(264);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rcid_pkg.sv
rtl/core/rcid_cell.sv
rtl/core/rcid_ring.sv
rtl/core/refcounted_id_allocator.sv
rtl/core/rcid_checker.sv
bench/tb_top.sv
